/* hw/rtl/deq_occ_pkg.sv */
package deq_occ_pkg;

  localparam int unsigned COORD_W   = 5;
  localparam int unsigned ENTRIES_W = 11;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4
  } deq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } deq_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic   wr;
    logic   set;
    point_t pt;
  } cell_req_t;

endpackage

/* hw/rtl/deq_occ_ring_mem.sv */
module deq_occ_ring_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  deq_occ_pkg::point_t   wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  output deq_occ_pkg::point_t   rd_data_o
);

  deq_occ_pkg::point_t mem [DEPTH];
  deq_occ_pkg::point_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/deq_occ_cell_map.sv */
module deq_occ_cell_map #(
  parameter int unsigned GRID_DIM = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  deq_occ_pkg::cell_req_t   req_i,
  output logic                     busy_o
);

  localparam int unsigned CELLS   = GRID_DIM * GRID_DIM;
  localparam int unsigned CELL_AW = $clog2(CELLS);

  logic                mem [CELLS];
  logic [CELL_AW-1:0]  clr_q, clr_d;
  logic                clearing_q, clearing_d;
  logic                in_grid;
  logic [CELL_AW-1:0]  req_addr;
  logic                wr_en;
  logic [CELL_AW-1:0]  wr_addr;
  logic                wr_val;

  assign in_grid  = (32'(req_i.pt.x) < 32'(GRID_DIM)) && (32'(req_i.pt.y) < 32'(GRID_DIM));
  assign req_addr = CELL_AW'(32'(req_i.pt.x) * 32'(GRID_DIM) + 32'(req_i.pt.y));

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    wr_en      = 1'b0;
    wr_addr    = req_addr;
    wr_val     = req_i.set;
    if (clearing_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_val  = 1'b0;
      clr_d   = clr_q + CELL_AW'(1);
      if (clr_q == CELL_AW'(CELLS - 1)) begin
        clearing_d = 1'b0;
      end
    end else if (req_i.wr && in_grid) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_q      <= clr_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_val;
    end
  end

  assign busy_o = clearing_q;

endmodule

/* hw/rtl/deque_with_occupancy_grid.sv */
// Double-ended queue of grid points with an occupancy map of the grid.
// Input channel: op_i, pos_x_i, pos_y_i, transferred when in_valid_i is high
// and in_stall_o is low. Ops: push front, push rear, pop front, pop rear,
// peek (unused codes act as peek). Output channel: one result per input
// transfer, taken when out_valid_o is high and out_stall_i is low. A result
// carries the front and rear points after the op, the point removed by a
// successful pop, the count held and a status (ok, empty, full).
// Front and rear points are cached in registers; the point ring sits in a
// one-port-read synchronous memory. A pop that leaves one or more points
// reads the new end point from the ring in a fetch state before the emit
// state. One item is in flight at a time. A finished result waits in the
// emit state while the output register holds an unaccepted result and
// out_stall_i is high; the next item is held off until the finished result
// has moved into the output register.
// After reset the occupancy map is swept clear, one cell per cycle, over all
// GRID_DIM*GRID_DIM cells; in_stall_o stays high during the sweep.
module deque_with_occupancy_grid #(
  parameter int unsigned GRID_DIM    = 32,
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [deq_occ_pkg::OP_W-1:0]         op_i,
  input  logic [deq_occ_pkg::COORD_W-1:0]      pos_x_i,
  input  logic [deq_occ_pkg::COORD_W-1:0]      pos_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [deq_occ_pkg::COORD_W-1:0]      front_x_o,
  output logic [deq_occ_pkg::COORD_W-1:0]      front_y_o,
  output logic [deq_occ_pkg::COORD_W-1:0]      rear_x_o,
  output logic [deq_occ_pkg::COORD_W-1:0]      rear_y_o,
  output logic [deq_occ_pkg::COORD_W-1:0]      popped_x_o,
  output logic [deq_occ_pkg::COORD_W-1:0]      popped_y_o,
  output logic [deq_occ_pkg::ENTRIES_W-1:0]    entries_o,
  output logic [deq_occ_pkg::STATUS_W-1:0]     status_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  deq_occ_pkg::deq_state_e  state_q, state_d;
  logic [PTR_W-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  deq_occ_pkg::point_t      front_q, front_d, rear_q, rear_d, popped_q, popped_d;
  deq_occ_pkg::deq_status_e status_q, status_d;
  logic                     fetch_front_q, fetch_front_d;

  logic                     in_stall;
  logic                     occ_busy;
  deq_occ_pkg::cell_req_t   cell_req;
  deq_occ_pkg::point_t      pt_in, rd_data, wr_data;
  logic                     wr_en, rd_en;
  logic [PTR_W-1:0]         wr_addr, rd_addr;
  logic [PTR_W-1:0]         head_p1, head_m1, tail_p1, tail_m1;
  logic                     empty, full, last;
  logic                     out_load;

  logic                     out_valid_q;
  deq_occ_pkg::point_t      out_front_q, out_rear_q, out_popped_q;
  logic [CNT_W-1:0]         out_cnt_q;
  deq_occ_pkg::deq_status_e out_status_q;

  assign pt_in   = '{x: pos_x_i, y: pos_y_i};
  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign last    = (cnt_q == CNT_W'(1));
  assign head_p1 = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign head_m1 = (head_q == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_q - PTR_W'(1);
  assign tail_p1 = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
  assign tail_m1 = (tail_q == '0) ? PTR_W'(QUEUE_DEPTH - 1) : tail_q - PTR_W'(1);

  assign in_stall   = (state_q != deq_occ_pkg::S_IDLE) || occ_busy;
  assign in_stall_o = in_stall;

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    cnt_d         = cnt_q;
    front_d       = front_q;
    rear_d        = rear_q;
    popped_d      = popped_q;
    status_d      = status_q;
    fetch_front_d = fetch_front_q;
    wr_en         = 1'b0;
    wr_addr       = head_q;
    wr_data       = pt_in;
    rd_en         = 1'b0;
    rd_addr       = head_p1;
    cell_req      = '0;
    out_load      = 1'b0;
    unique case (state_q)
      deq_occ_pkg::S_IDLE: begin
        if (in_valid_i && !in_stall) begin
          popped_d = '0;
          status_d = deq_occ_pkg::ST_OK;
          state_d  = deq_occ_pkg::S_EMIT;
          unique case (deq_occ_pkg::deq_op_e'(op_i))
            deq_occ_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                status_d = deq_occ_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = head_m1;
                head_d   = head_m1;
                cnt_d    = cnt_q + CNT_W'(1);
                front_d  = pt_in;
                cell_req = '{wr: 1'b1, set: 1'b1, pt: pt_in};
                if (empty) begin
                  rear_d = pt_in;
                  tail_d = head_m1;
                end
              end
            end
            deq_occ_pkg::OP_PUSH_REAR: begin
              if (full) begin
                status_d = deq_occ_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = empty ? head_q : tail_p1;
                tail_d   = empty ? head_q : tail_p1;
                cnt_d    = cnt_q + CNT_W'(1);
                rear_d   = pt_in;
                cell_req = '{wr: 1'b1, set: 1'b1, pt: pt_in};
                if (empty) begin
                  front_d = pt_in;
                end
              end
            end
            deq_occ_pkg::OP_POP_FRONT: begin
              if (empty) begin
                status_d = deq_occ_pkg::ST_EMPTY;
              end else begin
                popped_d = front_q;
                cell_req = '{wr: 1'b1, set: 1'b0, pt: front_q};
                head_d   = head_p1;
                cnt_d    = cnt_q - CNT_W'(1);
                if (last) begin
                  front_d = '0;
                  rear_d  = '0;
                end else begin
                  rd_en         = 1'b1;
                  rd_addr       = head_p1;
                  fetch_front_d = 1'b1;
                  state_d       = deq_occ_pkg::S_FETCH;
                end
              end
            end
            deq_occ_pkg::OP_POP_REAR: begin
              if (empty) begin
                status_d = deq_occ_pkg::ST_EMPTY;
              end else begin
                popped_d = rear_q;
                cell_req = '{wr: 1'b1, set: 1'b0, pt: rear_q};
                tail_d   = tail_m1;
                cnt_d    = cnt_q - CNT_W'(1);
                if (last) begin
                  front_d = '0;
                  rear_d  = '0;
                end else begin
                  rd_en         = 1'b1;
                  rd_addr       = tail_m1;
                  fetch_front_d = 1'b0;
                  state_d       = deq_occ_pkg::S_FETCH;
                end
              end
            end
            default: begin
              if (empty) begin
                status_d = deq_occ_pkg::ST_EMPTY;
              end
            end
          endcase
        end
      end
      deq_occ_pkg::S_FETCH: begin
        if (fetch_front_q) begin
          front_d = rd_data;
        end else begin
          rear_d = rd_data;
        end
        state_d = deq_occ_pkg::S_EMIT;
      end
      deq_occ_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = deq_occ_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = deq_occ_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= deq_occ_pkg::S_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      cnt_q         <= '0;
      front_q       <= '0;
      rear_q        <= '0;
      popped_q      <= '0;
      status_q      <= deq_occ_pkg::ST_OK;
      fetch_front_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      cnt_q         <= cnt_d;
      front_q       <= front_d;
      rear_q        <= rear_d;
      popped_q      <= popped_d;
      status_q      <= status_d;
      fetch_front_q <= fetch_front_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_front_q  <= front_q;
      out_rear_q   <= rear_q;
      out_popped_q <= popped_q;
      out_cnt_q    <= cnt_q;
      out_status_q <= status_q;
    end
  end

  deq_occ_ring_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  deq_occ_cell_map #(
    .GRID_DIM (GRID_DIM)
  ) u_cells (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cell_req),
    .busy_o (occ_busy)
  );

  assign out_valid_o = out_valid_q;
  assign front_x_o   = out_front_q.x;
  assign front_y_o   = out_front_q.y;
  assign rear_x_o    = out_rear_q.x;
  assign rear_y_o    = out_rear_q.y;
  assign popped_x_o  = out_popped_q.x;
  assign popped_y_o  = out_popped_q.y;
  assign entries_o   = deq_occ_pkg::ENTRIES_W'(out_cnt_q);
  assign status_o    = out_status_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("count above depth");

  a_empty_ends_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (front_q == '0 && rear_q == '0))
    else $error("cached ends not cleared on empty queue");

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == deq_occ_pkg::S_EMIT))
    else $error("result raised outside emit state");

  a_cnt_moves_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(in_valid_i && !in_stall))
    else $error("count changed without an input transfer");
`endif

endmodule
